[hw/rtl/lpsc_pkg.sv]
package lpsc_pkg;

  // default slot count of the cache
  localparam int SLOTS_DEF = 16;

  // fixed field widths
  localparam int PAGE_W  = 64;
  localparam int CFG_W   = 5;
  localparam int SLOT_OW = 4;

  // reset value of the slot limit register
  localparam logic [CFG_W-1:0] LIMIT_RST = 5'd16;

  // command codes
  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

endpackage

[hw/rtl/lru_page_slot_cache_unit.sv]
// fully associative page tag store with least recently used replacement
//
// input channel (in_valid / in_ready) takes one word: command and page_number.
// a find returns the slot of a present page and makes it most recent; an
// insert of a missing page fills the lowest free slot while the fill is below
// the limit in cfg_wdata (written with cfg_we while idle), else it replaces
// the least recently used entry and reports the page it held.
// output channel (out_valid / out_ready) gives one word per input word.
//
// one compare unit and one rank port visit one slot per cycle: a lookup scan
// over every slot, a decision state, then a rank update sweep over every
// slot (skipped on a find miss), and a done state to hand the word over.
// in_ready is high only in the idle state, so a new word is taken only once
// the previous one has left the done state.
// the result sits in an output register, so a new word can be accepted while
// the previous result waits; a stalled receiver holds a finished result in
// the work registers until the output register frees up.
// reset empties the cache (all valid bits and the fill count cleared) and
// sets the limit to 16; page and rank memories need no clearing.
module lru_page_slot_cache_unit #(
  parameter int SLOTS = lpsc_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [lpsc_pkg::CFG_W-1:0]      cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [lpsc_pkg::PAGE_W-1:0]     page_number,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [lpsc_pkg::SLOT_OW-1:0]    slot_index,
  output logic                            evicted,
  output logic [lpsc_pkg::PAGE_W-1:0]     evicted_page
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index width
  localparam int RW = IW;                                // rank width
  localparam int CW = $clog2(SLOTS + 1);                 // count width
  localparam int LW = (CW > lpsc_pkg::CFG_W) ? CW : lpsc_pkg::CFG_W;
  localparam int PW = lpsc_pkg::PAGE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

  logic [2:0]              state;
  logic [lpsc_pkg::CFG_W-1:0] slots_in_use;

  // request registers
  logic                    cmd;
  logic [PW-1:0]           page;

  // cache state
  logic [SLOTS-1:0]        entry_valid;
  logic [CW-1:0]           filled_count;
  logic [PW-1:0]           page_mem [SLOTS];
  logic [RW-1:0]           rank_mem [SLOTS];

  // slot sweep
  logic [CW-1:0]           rd_idx;
  logic                    pipe_vld;
  logic [IW-1:0]           pipe_idx;
  logic [PW-1:0]           rd_page;
  logic [RW-1:0]           rd_rank;

  // scan trackers
  logic                    hit_found;
  logic [IW-1:0]           hit_idx;
  logic [RW-1:0]           hit_rank;
  logic                    free_found;
  logic [IW-1:0]           free_idx;
  logic                    best_found;
  logic [IW-1:0]           best_idx;
  logic [RW-1:0]           best_rank;
  logic [PW-1:0]           best_page;

  // update target
  logic [IW-1:0]           upd_slot;
  logic [RW-1:0]           upd_rank;

  // work result
  logic                    res_hit;
  logic [IW-1:0]           res_slot;
  logic                    res_evicted;
  logic [PW-1:0]           res_evpage;

  // memory ports
  logic                    page_we;
  logic [IW-1:0]           page_waddr;
  logic                    rank_we;
  logic [IW-1:0]           rank_waddr;
  logic [RW-1:0]           rank_wdata;
  logic [IW-1:0]           rd_addr;

  // effective limit and fill compare
  logic [LW-1:0]           cfg_ext;
  logic [LW-1:0]           slots_ext;
  logic [LW-1:0]           limit;
  logic                    has_room;
  logic                    pipe_entry_valid;
  logic                    sweeping;
  logic                    out_load;
  logic [IW+lpsc_pkg::SLOT_OW-1:0] slot_ext;

  assign in_ready = (state == S_IDLE);
  assign sweeping = ((state == S_SCAN) || (state == S_UPD)) && (rd_idx != SLOTS_CNT);
  assign rd_addr  = rd_idx[IW-1:0];
  assign pipe_entry_valid = entry_valid[pipe_idx];

  // a limit of zero acts as one, above SLOTS as SLOTS
  always_comb begin
    cfg_ext   = LW'(slots_in_use);
    slots_ext = LW'(SLOTS);
    if (cfg_ext == '0) begin
      limit = LW'(1);
    end else if (cfg_ext > slots_ext) begin
      limit = slots_ext;
    end else begin
      limit = cfg_ext;
    end
    has_room = LW'(filled_count) < limit;
  end

  // page memory write at the decision of an insert that misses
  always_comb begin
    page_we    = 1'b0;
    page_waddr = best_idx;
    if ((state == S_DEC) && !hit_found && (cmd == lpsc_pkg::CMD_INSERT)) begin
      page_we    = 1'b1;
      page_waddr = has_room ? free_idx : best_idx;
    end
  end

  // rank sweep: target slot becomes most recent, more recent valid ones age
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = pipe_idx;
    rank_wdata = rd_rank;
    if ((state == S_UPD) && pipe_vld) begin
      if (pipe_idx == upd_slot) begin
        rank_we    = 1'b1;
        rank_wdata = '0;
      end else if (pipe_entry_valid && (rd_rank < upd_rank)) begin
        rank_we    = 1'b1;
        rank_wdata = RW'(rd_rank + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (page_we) begin
      page_mem[page_waddr] <= page;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rd_page <= page_mem[rd_addr];
    rd_rank <= rank_mem[rd_addr];
  end

  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slots_in_use <= lpsc_pkg::LIMIT_RST;
      entry_valid  <= '0;
      filled_count <= '0;
      rd_idx       <= '0;
      pipe_vld     <= 1'b0;
      hit_found    <= 1'b0;
      free_found   <= 1'b0;
      best_found   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_wdata;
      end

      pipe_vld <= sweeping;
      if (sweeping) begin
        pipe_idx <= rd_idx[IW-1:0];
        rd_idx   <= rd_idx + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            page       <= page_number;
            rd_idx     <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (pipe_vld) begin
            if (pipe_entry_valid) begin
              if (!hit_found && (rd_page == page)) begin
                hit_found <= 1'b1;
                hit_idx   <= pipe_idx;
                hit_rank  <= rd_rank;
              end
              if (!best_found || (rd_rank > best_rank)) begin
                best_found <= 1'b1;
                best_idx   <= pipe_idx;
                best_rank  <= rd_rank;
                best_page  <= rd_page;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= pipe_idx;
            end
          end
          if (rd_idx == SLOTS_CNT) begin
            state <= S_DEC;
          end
        end

        S_DEC: begin
          rd_idx      <= '0;
          res_hit     <= 1'b0;
          res_slot    <= '0;
          res_evicted <= 1'b0;
          res_evpage  <= '0;
          priority if (hit_found) begin
            res_hit  <= 1'b1;
            res_slot <= hit_idx;
            upd_slot <= hit_idx;
            upd_rank <= hit_rank;
            state    <= S_UPD;
          end else if (cmd == lpsc_pkg::CMD_FIND) begin
            state <= S_DONE;
          end else if (has_room) begin
            // every valid rank is below the fill, so all of them age
            entry_valid[free_idx] <= 1'b1;
            filled_count          <= filled_count + 1'b1;
            res_slot              <= free_idx;
            upd_slot              <= free_idx;
            upd_rank              <= filled_count[RW-1:0];
            state                 <= S_UPD;
          end else begin
            res_slot    <= best_idx;
            res_evicted <= 1'b1;
            res_evpage  <= best_page;
            upd_slot    <= best_idx;
            upd_rank    <= best_rank;
            state       <= S_UPD;
          end
        end

        S_UPD: begin
          if (rd_idx == SLOTS_CNT) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      hit          <= res_hit;
      slot_ext     <= {{lpsc_pkg::SLOT_OW{1'b0}}, res_slot};
      evicted      <= res_evicted;
      evicted_page <= res_evpage;
    end
  end

  // low bits of the slot number
  assign slot_index = slot_ext[lpsc_pkg::SLOT_OW-1:0];

endmodule

[bench/lru_page_slot_cache_unit_test.sv]
`timescale 1ns / 1ps

module lru_page_slot_cache_unit_test;

  localparam int SLOTS = lpsc_pkg::SLOTS_DEF;
  // wait long enough for a full lookup plus rank sweep, with some margin
  localparam int SETTLE_CYCLES = 2 * SLOTS + 12;
  localparam int IDLE_PCT = 29;

  // one result word as the block hands it over
  typedef struct packed {
    logic                            hit;
    logic [lpsc_pkg::SLOT_OW-1:0]    slot_index;
    logic                            evicted;
    logic [lpsc_pkg::PAGE_W-1:0]     evicted_page;
  } lookup_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [lpsc_pkg::CFG_W-1:0]      cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            command = lpsc_pkg::CMD_FIND;
  logic [lpsc_pkg::PAGE_W-1:0]     page_number = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            hit;
  logic [lpsc_pkg::SLOT_OW-1:0]    slot_index;
  logic                            evicted;
  logic [lpsc_pkg::PAGE_W-1:0]     evicted_page;

  // shadow copy of the tag store, kept in step with every accepted word
  logic                            tag_valid [SLOTS];
  logic [lpsc_pkg::PAGE_W-1:0]     tag_page  [SLOTS];
  int unsigned                     tag_rank  [SLOTS];
  int unsigned                     fill_count;
  logic [lpsc_pkg::CFG_W-1:0]      slot_limit;

  // results still owed by the block, oldest first
  lookup_word_t         expected_words[$];

  // shared between the sender, the receiver and the tests
  bit                   no_idle = 1'b0;
  int                   hold_cycles = 0;
  int                   mismatch_count = 0;
  int                   finds_sent = 0;
  int                   inserts_sent = 0;
  int                   hits_seen = 0;
  int                   evictions_seen = 0;
  int                   limit_writes = 0;

  lru_page_slot_cache_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .slot_index   (slot_index),
    .evicted      (evicted),
    .evicted_page (evicted_page)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // generous fixed bound on the whole run
  initial begin
    #1_500_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tag store prediction
  // ---------------------------------------------------------------------------

  // limit register as the block applies it: 0 behaves as 1, above SLOTS clips
  function automatic int unsigned effective_limit();
    if (slot_limit == 0) return 1;
    if (slot_limit > SLOTS) return SLOTS;
    return slot_limit;
  endfunction

  // slot s becomes rank 0, every valid entry that was more recent ages by one
  function automatic void make_most_recent(int s);
    int unsigned old_rank;
    int i;
    old_rank = tag_rank[s];
    for (i = 0; i < SLOTS; i++)
      if (tag_valid[i] && tag_rank[i] < old_rank) tag_rank[i]++;
    tag_rank[s] = 0;
  endfunction

  // applies one find or insert to the shadow store, returns the result word
  function automatic lookup_word_t cache_access(logic cmd,
                                                logic [lpsc_pkg::PAGE_W-1:0] page);
    lookup_word_t res;
    int found;
    int victim;
    int i;
    res = '0;
    found = -1;
    victim = -1;
    for (i = 0; i < SLOTS; i++)
      if (found < 0 && tag_valid[i] && tag_page[i] == page) found = i;
    if (found >= 0) begin
      // find hit or insert of a page already present: refresh only
      make_most_recent(found);
      res.hit = 1'b1;
      res.slot_index = lpsc_pkg::SLOT_OW'(found);
    end else if (cmd == lpsc_pkg::CMD_INSERT) begin
      if (fill_count < effective_limit()) begin
        // room left: lowest free slot, everything else ages
        for (i = 0; i < SLOTS; i++)
          if (victim < 0 && !tag_valid[i]) victim = i;
        for (i = 0; i < SLOTS; i++)
          if (tag_valid[i]) tag_rank[i]++;
        tag_valid[victim] = 1'b1;
        tag_page[victim] = page;
        tag_rank[victim] = 0;
        fill_count++;
      end else begin
        // at or over the limit: replace the oldest valid entry in place
        for (i = 0; i < SLOTS; i++)
          if (tag_valid[i] && (victim < 0 || tag_rank[i] > tag_rank[victim])) victim = i;
        res.evicted = 1'b1;
        res.evicted_page = tag_page[victim];
        tag_page[victim] = page;
        make_most_recent(victim);
      end
      res.slot_index = lpsc_pkg::SLOT_OW'(victim);
    end
    // a find miss leaves every field zero and the store untouched
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offers one request word, predicts its result once the block takes it;
  // valid is only dropped on a random idle cycle, never in the accepting step
  task automatic send_request(input logic cmd, input logic [lpsc_pkg::PAGE_W-1:0] page);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    page_number <= page;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(cache_access(cmd, page));
    if (cmd == lpsc_pkg::CMD_INSERT) inserts_sent++;
    else finds_sent++;
  endtask

  // only called while nothing is in flight
  task automatic write_limit(input logic [lpsc_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_limit = value;
    limit_writes++;
  endtask

  // stop offering, wait for every owed result, then let the sweep finish
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, optional long hold-off, field checks
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    lookup_word_t want;
    forever begin
      @(posedge clk);
      // values seen here are the ones the edge sampled
      if (!rst && out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: hit %0b slot %0d",
                                    hit, slot_index));
        end else begin
          want = expected_words.pop_front();
          if (want.hit) hits_seen++;
          if (want.evicted) evictions_seen++;
          if (hit !== want.hit)
            report_mismatch($sformatf("hit expected %0b got %0b", want.hit, hit));
          if (slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index expected %0d got %0d",
                                      want.slot_index, slot_index));
          if (evicted !== want.evicted)
            report_mismatch($sformatf("evicted expected %0b got %0b",
                                      want.evicted, evicted));
          if (evicted_page !== want.evicted_page)
            report_mismatch($sformatf("evicted_page expected %h got %h",
                                      want.evicted_page, evicted_page));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty cache, extreme page numbers, insert of a page already present
  task automatic test_empty_and_extremes();
    send_request(lpsc_pkg::CMD_FIND, '0);
    send_request(lpsc_pkg::CMD_FIND, '1);
    send_request(lpsc_pkg::CMD_INSERT, '0);
    send_request(lpsc_pkg::CMD_INSERT, '1);
    send_request(lpsc_pkg::CMD_INSERT, 64'h8000_0000_0000_0000);
    send_request(lpsc_pkg::CMD_FIND, '1);
    send_request(lpsc_pkg::CMD_INSERT, '0);
    send_request(lpsc_pkg::CMD_FIND, 64'h0000_0000_0000_0001);
    wait_until_idle();
  endtask

  // limit of zero (acts as one, below the current fill), then above SLOTS
  task automatic test_limit_extremes();
    write_limit('0);
    send_request(lpsc_pkg::CMD_INSERT, 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(lpsc_pkg::CMD_INSERT, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(lpsc_pkg::CMD_FIND, 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(lpsc_pkg::CMD_FIND, 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(lpsc_pkg::CMD_INSERT, 64'h5A5A_5A5A_5A5A_5A5A);
    wait_until_idle();
    write_limit('1);
    send_request(lpsc_pkg::CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(lpsc_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF);
    send_request(lpsc_pkg::CMD_FIND, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(lpsc_pkg::CMD_FIND, '1);
    wait_until_idle();
  endtask

  // mostly pages from a working set sized around the cache, so finds hit,
  // inserts refresh and evictions all happen; the rest are fresh or extreme
  task automatic test_random_traffic(input int count,
                                     input logic [lpsc_pkg::CFG_W-1:0] limit_value,
                                     input bit steady);
    logic [lpsc_pkg::PAGE_W-1:0] working_set[$];
    logic [lpsc_pkg::PAGE_W-1:0] page;
    logic                        cmd;
    int unsigned                 reach;
    int                          sel;
    write_limit(limit_value);
    reach = (fill_count > effective_limit()) ? fill_count : effective_limit();
    repeat (reach + $urandom_range(1, reach / 2 + 3))
      working_set.push_back({$urandom, $urandom});
    no_idle = steady;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 85) page = working_set[$urandom_range(working_set.size() - 1)];
      else if (sel < 95) page = {$urandom, $urandom};
      else page = sel[0] ? '1 : '0;
      cmd = ($urandom_range(99) < 55) ? lpsc_pkg::CMD_INSERT : lpsc_pkg::CMD_FIND;
      send_request(cmd, page);
    end
    wait_until_idle();
    no_idle = 1'b0;
  endtask

  // receiver holds off for a long stretch while requests keep coming, so the
  // output register and the work registers fill and in_ready stays low
  task automatic test_output_stall();
    int i;
    hold_cycles = 300;
    for (i = 0; i < 12; i++)
      send_request(i[0] ? lpsc_pkg::CMD_FIND : lpsc_pkg::CMD_INSERT,
                   {32'hC0DE_0000, 28'd0, 4'(i % 5)});
    wait_until_idle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int i;
    for (i = 0; i < SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_page[i] = '0;
      tag_rank[i] = 0;
    end
    fill_count = 0;
    slot_limit = lpsc_pkg::LIMIT_RST;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_extremes();
    test_limit_extremes();
    // limits rising with the fill, then lowered below it
    test_random_traffic(150, 5'd3, 1'b0);
    test_random_traffic(150, 5'd6, 1'b0);
    test_random_traffic(150, 5'd11, 1'b0);
    test_random_traffic(250, 5'd31, 1'b1);
    test_random_traffic(150, 5'd4, 1'b0);
    test_random_traffic(120, 5'd0, 1'b0);
    test_random_traffic(100, 5'd1, 1'b0);
    test_random_traffic(150, 5'd16, 1'b0);
    test_output_stall();
    repeat (3) test_random_traffic(160, lpsc_pkg::CFG_W'($urandom_range(0, 31)), 1'b0);

    wait_until_idle();
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));

    $display("run covered %0d finds and %0d inserts across %0d limit writes",
             finds_sent, inserts_sent, limit_writes);
    $display("%0d hits and %0d evictions were checked", hits_seen, evictions_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
